[hw/rtl/mfr_pkg.sv]
// ----------------------------------------------------------------------------
// mfr_pkg
// Shared constants and types of the multidrop frame receiver.
// ----------------------------------------------------------------------------
package mfr_pkg;

  // default sizes
  localparam int NODES_DEF    = 4;
  localparam int MAX_DATA_DEF = 64;

  // fixed field widths
  localparam int CMD_W     = 3;
  localparam int NODE_IN_W = 2;
  localparam int IDX_W     = 6;
  localparam int FLEN_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int STAT_W    = 3;

  // commands
  localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;

  // completion status
  localparam logic [STAT_W-1:0] ST_DATA_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_POLL_OK    = 3'd1;
  localparam logic [STAT_W-1:0] ST_IDLE_TMO   = 3'd2;
  localparam logic [STAT_W-1:0] ST_WRONG_ADDR = 3'd3;
  localparam logic [STAT_W-1:0] ST_INCOMPLETE = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_TYPE   = 3'd5;
  localparam logic [STAT_W-1:0] ST_OVERRUN    = 3'd6;
  localparam logic [STAT_W-1:0] ST_CHECKSUM   = 3'd7;

  // result kinds
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_MASTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE = 2'd2;

  // result of one item, before the buffer data byte is merged in
  typedef struct packed {
    logic              kind;
    logic [STAT_W-1:0] status;
    logic [7:0]        src;
    logic [7:0]        dest;
    logic [FLEN_W-1:0] len;
    logic [7:0]        hw_src;
    logic              full;
    logic [7:0]        master;
    logic              data_zero;
  } result_t;

endpackage

[hw/rtl/mfr_if.sv]
// ----------------------------------------------------------------------------
// mfr_if
// Valid/ready channels of the multidrop frame receiver.
// ----------------------------------------------------------------------------

// input event channel
interface mfr_in_if;
  logic                           valid;
  logic                           ready;
  logic [mfr_pkg::CMD_W-1:0]      command;
  logic [7:0]                     rx_byte;
  logic                           address_bit;
  logic [mfr_pkg::NODE_IN_W-1:0]  node_index;
  logic [mfr_pkg::IDX_W-1:0]      byte_index;

  modport source (output valid, command, rx_byte, address_bit, node_index, byte_index,
                  input ready);
  modport sink   (input valid, command, rx_byte, address_bit, node_index, byte_index,
                  output ready);
endinterface

// result channel
interface mfr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic [mfr_pkg::STAT_W-1:0]   status;
  logic [7:0]                   data_byte;
  logic [7:0]                   frame_source;
  logic [7:0]                   frame_dest;
  logic [mfr_pkg::FLEN_W-1:0]   frame_length;
  logic [7:0]                   frame_hw_source;
  logic                         buffer_full;
  logic [7:0]                   master_address;

  modport source (output valid, result_kind, status, data_byte, frame_source, frame_dest,
                         frame_length, frame_hw_source, buffer_full, master_address,
                  input ready);
  modport sink   (input valid, result_kind, status, data_byte, frame_source, frame_dest,
                        frame_length, frame_hw_source, buffer_full, master_address,
                  output ready);
endinterface

// configuration write channel
interface mfr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mfr_pkg::CFG_IDX_W-1:0]  index;
  logic [7:0]                     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/mfr_ram.sv]
// ----------------------------------------------------------------------------
// mfr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfr_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/mfr_parse.sv]
// ----------------------------------------------------------------------------
// mfr_parse
// Frame parser: phase sequencer, checksum, header and full-flag state, and
// address generation for the data buffer RAM.
// ----------------------------------------------------------------------------
module mfr_parse #(
  parameter  int NODES    = mfr_pkg::NODES_DEF,
  parameter  int MAX_DATA = mfr_pkg::MAX_DATA_DEF,
  localparam int AW       = $clog2(NODES * MAX_DATA)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic [7:0]                      node_address,
  input  logic                            is_master,
  input  logic                            data_type_code,
  // accepted item
  input  logic                            accept,
  input  logic [mfr_pkg::CMD_W-1:0]       in_command,
  input  logic [7:0]                      in_byte,
  input  logic                            in_abit,
  input  logic [mfr_pkg::NODE_IN_W-1:0]   in_node,
  input  logic [mfr_pkg::IDX_W-1:0]       in_idx,
  // result of this item
  output logic                            res_valid,
  output mfr_pkg::result_t                res,
  // data buffer RAM
  output logic                            ram_we,
  output logic [AW-1:0]                   ram_waddr,
  output logic [7:0]                      ram_wdata,
  output logic                            ram_re,
  output logic [AW-1:0]                   ram_raddr
);

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = $clog2(MAX_DATA + 1);
  localparam logic [7:0]    NODES_B = 8'(NODES);
  localparam logic [7:0]    MAXD_B  = 8'(MAX_DATA);
  localparam logic [LW-1:0] MAXD_L  = LW'(MAX_DATA);
  localparam logic [AW-1:0] MAXD_A  = AW'(MAX_DATA);

  // frame phases
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_ADDR  = 4'd1;
  localparam logic [3:0] PH_HWSRC = 4'd2;
  localparam logic [3:0] PH_TYPE  = 4'd3;
  localparam logic [3:0] PH_SRC   = 4'd4;
  localparam logic [3:0] PH_DEST  = 4'd5;
  localparam logic [3:0] PH_LEN   = 4'd6;
  localparam logic [3:0] PH_DATA  = 4'd7;
  localparam logic [3:0] PH_SUMD  = 4'd8;
  localparam logic [3:0] PH_SUMP  = 4'd9;

  logic [3:0]                     phase_r, phase_nxt;
  logic [7:0]                     sum_r, sum_nxt;
  logic [mfr_pkg::NODE_IN_W-1:0]  polled_r, polled_nxt;
  logic [7:0]                     hw_src_r, hw_src_nxt;
  logic [7:0]                     src_r, src_nxt;
  logic [7:0]                     dest_r, dest_nxt;
  logic [LW-1:0]                  len_r, len_nxt;
  logic [LW-1:0]                  cnt_r, cnt_nxt;
  logic [7:0]                     master_r, master_nxt;
  logic [NODES-1:0]               full_r, full_nxt;
  logic [7:0]                     hh_hw_r   [NODES];
  logic [7:0]                     hh_hw_nxt [NODES];
  logic [7:0]                     hh_src_r   [NODES];
  logic [7:0]                     hh_src_nxt [NODES];
  logic [7:0]                     hh_dest_r   [NODES];
  logic [7:0]                     hh_dest_nxt [NODES];
  logic [LW-1:0]                  hh_len_r   [NODES];
  logic [LW-1:0]                  hh_len_nxt [NODES];

  logic [7:0]    tgt;
  logic          tgt_ok;
  logic [NW-1:0] tgt_i;
  logic          na_ok;
  logic [NW-1:0] na_i;
  logic          node_ok;
  logic [NW-1:0] node_i;
  logic          idx_ok;
  logic          polled_ok;
  logic [NW-1:0] polled_i;
  logic          b_ok;
  logic [NW-1:0] b_i;
  logic [7:0]    sum_x;
  logic [LW-1:0] cnt_inc;
  logic [15:0]   len_ext;

  // buffer selection and range checks
  always_comb begin
    tgt       = is_master ? dest_r : node_address;
    tgt_ok    = tgt < NODES_B;
    tgt_i     = NW'(tgt);
    na_ok     = node_address < NODES_B;
    na_i      = NW'(node_address);
    node_ok   = 8'(in_node) < NODES_B;
    node_i    = NW'(in_node);
    idx_ok    = 8'(in_idx) < MAXD_B;
    polled_ok = 8'(polled_r) < NODES_B;
    polled_i  = NW'(polled_r);
    b_ok      = in_byte < NODES_B;
    b_i       = NW'(in_byte);
    sum_x     = sum_r ^ in_byte;
    cnt_inc   = cnt_r + LW'(1);
    len_ext   = 16'(hh_len_r[node_i]);
  end

  // next state and result of the accepted item
  always_comb begin
    phase_nxt   = phase_r;
    sum_nxt     = sum_r;
    polled_nxt  = polled_r;
    hw_src_nxt  = hw_src_r;
    src_nxt     = src_r;
    dest_nxt    = dest_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    master_nxt  = master_r;
    full_nxt    = full_r;
    hh_hw_nxt   = hh_hw_r;
    hh_src_nxt  = hh_src_r;
    hh_dest_nxt = hh_dest_r;
    hh_len_nxt  = hh_len_r;

    res_valid     = 1'b0;
    res           = '0;
    res.master    = master_r;
    res.data_zero = 1'b1;

    ram_we      = 1'b0;
    ram_waddr   = AW'(tgt_i) * MAXD_A + AW'(cnt_r);
    ram_wdata   = in_byte;
    ram_re      = 1'b0;
    ram_raddr   = AW'(node_i) * MAXD_A + AW'(in_idx);

    if (accept) begin
      unique case (in_command)
        mfr_pkg::CMD_START: begin
          polled_nxt = in_node;
          sum_nxt    = '0;
          cnt_nxt    = '0;
          phase_nxt  = PH_ADDR;
        end

        mfr_pkg::CMD_BYTE: begin
          unique case (phase_r)
            PH_ADDR: begin
              if (in_abit) begin
                if (is_master && polled_ok) begin
                  full_nxt[polled_i] = 1'b0;
                end
                if (in_byte != node_address) begin
                  if (is_master) begin
                    res_valid  = 1'b1;
                    res.status = mfr_pkg::ST_WRONG_ADDR;
                    phase_nxt  = PH_IDLE;
                  end
                end else begin
                  sum_nxt   = node_address;
                  phase_nxt = PH_HWSRC;
                end
              end
            end
            PH_HWSRC: begin
              hw_src_nxt = in_byte;
              sum_nxt    = sum_x;
              if (!is_master) begin
                master_nxt = in_byte;
              end
              phase_nxt = PH_TYPE;
            end
            PH_TYPE: begin
              if (in_byte > 8'd1) begin
                res_valid  = 1'b1;
                res.status = mfr_pkg::ST_BAD_TYPE;
                phase_nxt  = PH_IDLE;
              end else begin
                sum_nxt = sum_x;
                if (in_byte[0] == data_type_code) begin
                  phase_nxt = PH_SRC;
                end else begin
                  if (na_ok) begin
                    hh_hw_nxt[na_i] = hw_src_r;
                  end
                  phase_nxt = PH_SUMP;
                end
              end
            end
            PH_SRC: begin
              src_nxt   = in_byte;
              sum_nxt   = sum_x;
              phase_nxt = PH_DEST;
            end
            PH_DEST: begin
              dest_nxt = in_byte;
              sum_nxt  = sum_x;
              if (!b_ok) begin
                res_valid  = 1'b1;
                res.status = mfr_pkg::ST_BAD_TYPE;
                phase_nxt  = PH_IDLE;
              end else if (is_master && full_r[b_i]) begin
                res_valid  = 1'b1;
                res.status = mfr_pkg::ST_OVERRUN;
                phase_nxt  = PH_IDLE;
              end else begin
                phase_nxt = PH_LEN;
              end
            end
            PH_LEN: begin
              sum_nxt = sum_x;
              if (in_byte > MAXD_B) begin
                res_valid  = 1'b1;
                res.status = mfr_pkg::ST_BAD_TYPE;
                phase_nxt  = PH_IDLE;
              end else begin
                len_nxt = LW'(in_byte);
                if (tgt_ok) begin
                  if (is_master) begin
                    hh_hw_nxt[tgt_i]   = node_address;
                    hh_dest_nxt[tgt_i] = dest_r;
                  end
                  hh_src_nxt[tgt_i] = src_r;
                  hh_len_nxt[tgt_i] = LW'(in_byte);
                end
                cnt_nxt   = '0;
                phase_nxt = (in_byte == 8'd0) ? PH_SUMD : PH_DATA;
              end
            end
            PH_DATA: begin
              ram_we  = tgt_ok && (cnt_r < MAXD_L);
              sum_nxt = sum_x;
              cnt_nxt = cnt_inc;
              if (cnt_inc >= len_r) begin
                phase_nxt = PH_SUMD;
              end
            end
            PH_SUMD: begin
              res_valid = 1'b1;
              phase_nxt = PH_IDLE;
              if (in_byte != sum_r) begin
                res.status = mfr_pkg::ST_CHECKSUM;
              end else begin
                res.status = mfr_pkg::ST_DATA_OK;
                if (tgt_ok) begin
                  full_nxt[tgt_i] = 1'b1;
                end
              end
            end
            PH_SUMP: begin
              res_valid  = 1'b1;
              res.status = (in_byte == sum_r) ? mfr_pkg::ST_POLL_OK : mfr_pkg::ST_CHECKSUM;
              phase_nxt  = PH_IDLE;
            end
            default: begin
            end
          endcase
        end

        mfr_pkg::CMD_TIMEOUT: begin
          if (phase_r != PH_IDLE) begin
            res_valid  = 1'b1;
            res.status = (phase_r == PH_ADDR) ? mfr_pkg::ST_IDLE_TMO
                                              : mfr_pkg::ST_INCOMPLETE;
            phase_nxt  = PH_IDLE;
          end
        end

        mfr_pkg::CMD_READ: begin
          res_valid     = 1'b1;
          res.kind      = mfr_pkg::KIND_READ;
          res.data_zero = !(node_ok && idx_ok);
          ram_re        = node_ok && idx_ok;
          if (node_ok) begin
            res.src    = hh_src_r[node_i];
            res.dest   = hh_dest_r[node_i];
            res.len    = len_ext[mfr_pkg::FLEN_W-1:0];
            res.hw_src = hh_hw_r[node_i];
            res.full   = full_r[node_i];
          end
        end

        mfr_pkg::CMD_RELEASE: begin
          if (node_ok) begin
            full_nxt[node_i] = 1'b0;
          end
        end

        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      sum_r    <= '0;
      polled_r <= '0;
      hw_src_r <= '0;
      src_r    <= '0;
      dest_r   <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      master_r <= '0;
      full_r   <= '0;
      for (int i = 0; i < NODES; i++) begin
        hh_hw_r[i]   <= '0;
        hh_src_r[i]  <= '0;
        hh_dest_r[i] <= '0;
        hh_len_r[i]  <= '0;
      end
    end else begin
      phase_r   <= phase_nxt;
      sum_r     <= sum_nxt;
      polled_r  <= polled_nxt;
      hw_src_r  <= hw_src_nxt;
      src_r     <= src_nxt;
      dest_r    <= dest_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      master_r  <= master_nxt;
      full_r    <= full_nxt;
      hh_hw_r   <= hh_hw_nxt;
      hh_src_r  <= hh_src_nxt;
      hh_dest_r <= hh_dest_nxt;
      hh_len_r  <= hh_len_nxt;
    end
  end

endmodule

[hw/rtl/multidrop_frame_receiver.sv]
// ----------------------------------------------------------------------------
// multidrop_frame_receiver
// Takes one bus event per item (start, received byte, timeout, buffer read,
// buffer release) and answers frame completions and buffer reads. Accepts
// one item every clock while the output is not stalled. A result passes
// the registered read of the data buffer RAM and then the output register
// on its way to the output. The parser state sits in flip-flops and is
// updated in the cycle of acceptance; the NODES x MAX_DATA data buffer is
// a single RAM with one write and one read port and needs no clearing
// after reset. Configuration is written through the cfg channel, which is
// always ready; write it only while no frame is in progress.
// ----------------------------------------------------------------------------
module multidrop_frame_receiver #(
  parameter int NODES    = mfr_pkg::NODES_DEF,
  parameter int MAX_DATA = mfr_pkg::MAX_DATA_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mfr_in_if.sink     in_ch,
  mfr_out_if.source  out_ch,
  mfr_cfg_if.sink    cfg_ch
);

  localparam int AW = $clog2(NODES * MAX_DATA);

  logic [7:0] node_address_r;
  logic       is_master_r;
  logic       data_type_r;

  logic             accept;
  logic             res_valid;
  mfr_pkg::result_t res;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  logic             s1_valid_r;
  mfr_pkg::result_t s1_r;
  logic             out_valid_r;
  mfr_pkg::result_t out_r;
  logic [7:0]       out_data_r;
  logic             adv;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_address_r <= 8'd1;
      is_master_r    <= 1'b0;
      data_type_r    <= 1'b1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        mfr_pkg::CFG_NODE_ADDR: node_address_r <= cfg_ch.data;
        mfr_pkg::CFG_IS_MASTER: is_master_r    <= cfg_ch.data[0];
        mfr_pkg::CFG_DATA_TYPE: data_type_r    <= cfg_ch.data[0];
        default: begin
        end
      endcase
    end
  end

  // handshake: the RAM stage moves on whenever the output register frees up
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv;
  assign accept      = in_ch.valid && in_ch.ready;

  mfr_parse #(
    .NODES    (NODES),
    .MAX_DATA (MAX_DATA)
  ) u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .node_address   (node_address_r),
    .is_master      (is_master_r),
    .data_type_code (data_type_r),
    .accept         (accept),
    .in_command     (in_ch.command),
    .in_byte        (in_ch.rx_byte),
    .in_abit        (in_ch.address_bit),
    .in_node        (in_ch.node_index),
    .in_idx         (in_ch.byte_index),
    .res_valid      (res_valid),
    .res            (res),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr)
  );

  mfr_ram #(
    .WIDTH (8),
    .DEPTH (NODES * MAX_DATA)
  ) u_data_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result waits here while the buffer read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= res_valid;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= res;
    end
  end

  // output register, data byte merged from the RAM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_r      <= s1_r;
      out_data_r <= s1_r.data_zero ? 8'd0 : ram_rdata;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_kind     = out_r.kind;
  assign out_ch.status          = out_r.status;
  assign out_ch.data_byte       = out_data_r;
  assign out_ch.frame_source    = out_r.src;
  assign out_ch.frame_dest      = out_r.dest;
  assign out_ch.frame_length    = out_r.len;
  assign out_ch.frame_hw_source = out_r.hw_src;
  assign out_ch.buffer_full     = out_r.full;
  assign out_ch.master_address  = out_r.master;

endmodule

[sim/tb_multidrop_frame_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multidrop_frame_receiver
// Self-checking bench for the multidrop frame receiver. A queue of bus
// events (frames built byte by byte, buffer reads and releases, noise) feeds
// a bursty valid/ready driver; a frame predictor runs over every item and
// the monitor checks each result, field by field, in order, under random
// back-pressure. Bus mode, node address and data type change between phases.
// ----------------------------------------------------------------------------
module tb_multidrop_frame_receiver;

  localparam int NODES       = mfr_pkg::NODES_DEF;
  localparam int MAX_DATA    = mfr_pkg::MAX_DATA_DEF;
  localparam int PHASE_ITEMS = 175;
  localparam int IDLE_LIMIT  = 2000;

  // commands that the block ignores
  localparam logic [mfr_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [mfr_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef enum logic [3:0] {
    RX_IDLE, RX_ADDR, RX_HWSRC, RX_TYPE, RX_SRC, RX_DEST, RX_LEN, RX_DATA, RX_SUMD, RX_SUMP
  } rx_phase_t;

  typedef struct packed {
    logic [mfr_pkg::CMD_W-1:0]     cmd;
    logic [7:0]                    rx;
    logic                          abit;
    logic [mfr_pkg::NODE_IN_W-1:0] node;
    logic [mfr_pkg::IDX_W-1:0]     idx;
  } bus_event_t;

  typedef struct packed {
    logic                       kind;
    logic [mfr_pkg::STAT_W-1:0] status;
    logic [7:0]                 data;
    logic [7:0]                 src;
    logic [7:0]                 dest;
    logic [mfr_pkg::FLEN_W-1:0] len;
    logic [7:0]                 hw_src;
    logic                       full;
    logic [7:0]                 master;
  } frame_result_t;

  typedef struct {
    bus_event_t    ev;
    bit            answers;
    frame_result_t res;
  } queued_event_t;

  typedef struct packed {
    logic [7:0]                 hw_src;
    logic [7:0]                 src;
    logic [7:0]                 dest;
    logic [mfr_pkg::FLEN_W-1:0] len;
  } buf_header_t;

  logic clk = 1'b0;
  logic rst_n;

  mfr_in_if  in_ch ();
  mfr_out_if out_ch ();
  mfr_cfg_if cfg_ch ();

  multidrop_frame_receiver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  // predictor copy of the registers
  logic [7:0] own_addr;
  logic       master_mode;
  logic       data_type;

  // predictor copy of the frame parser and buffers
  rx_phase_t                  rx_phase;
  logic [7:0]                 rx_sum;
  logic [1:0]                 poll_node;
  logic [7:0]                 cur_hw;
  logic [7:0]                 cur_src;
  logic [7:0]                 cur_dest;
  logic [mfr_pkg::FLEN_W-1:0] cur_len;
  logic [mfr_pkg::FLEN_W-1:0] data_cnt;
  logic [7:0]                 master_seen;
  logic                       buf_full [NODES];
  buf_header_t                buf_hdr [NODES];
  logic [7:0]                 buf_mem [NODES*MAX_DATA];
  bit                         buf_written [NODES*MAX_DATA];

  queued_event_t event_q [$];
  frame_result_t answer_q [$];
  queued_event_t on_bus;
  int            stim_count;
  int            mismatches;
  int            quiet;

  // ---------------------------------------------------------------- predictor

  function automatic frame_result_t close_frame(input logic [mfr_pkg::STAT_W-1:0] st);
    frame_result_t r;
    r        = '0;
    r.kind   = mfr_pkg::KIND_DONE;
    r.status = st;
    r.master = master_seen;
    rx_phase = RX_IDLE;
    return r;
  endfunction

  // buffer the current frame lands in, -1 when none
  function automatic int store_slot();
    int t;
    t = master_mode ? int'(cur_dest) : int'(own_addr);
    return (t < NODES) ? t : -1;
  endfunction

  function automatic bit byte_step(input logic [7:0] b, input logic abit,
                                   output frame_result_t r);
    int t;
    r = '0;
    case (rx_phase)
      RX_ADDR: begin
        if (!abit) return 0;
        if (master_mode) begin
          if (poll_node < NODES) buf_full[poll_node] = 1'b0;
          if (b != own_addr) begin
            r = close_frame(mfr_pkg::ST_WRONG_ADDR);
            return 1;
          end
        end else if (b != own_addr) begin
          return 0;
        end
        rx_sum   = own_addr;
        rx_phase = RX_HWSRC;
        return 0;
      end
      RX_HWSRC: begin
        cur_hw = b;
        rx_sum ^= b;
        if (!master_mode) master_seen = b;
        rx_phase = RX_TYPE;
        return 0;
      end
      RX_TYPE: begin
        if (b > 8'd1) begin
          r = close_frame(mfr_pkg::ST_BAD_TYPE);
          return 1;
        end
        rx_sum ^= b;
        if (b[0] == data_type) begin
          rx_phase = RX_SRC;
        end else begin
          // poll or token frame records the hardware source only
          if (own_addr < NODES) buf_hdr[own_addr].hw_src = cur_hw;
          rx_phase = RX_SUMP;
        end
        return 0;
      end
      RX_SRC: begin
        cur_src = b;
        rx_sum ^= b;
        rx_phase = RX_DEST;
        return 0;
      end
      RX_DEST: begin
        cur_dest = b;
        rx_sum ^= b;
        if (b >= NODES) begin
          r = close_frame(mfr_pkg::ST_BAD_TYPE);
          return 1;
        end
        if (master_mode && buf_full[b]) begin
          r = close_frame(mfr_pkg::ST_OVERRUN);
          return 1;
        end
        rx_phase = RX_LEN;
        return 0;
      end
      RX_LEN: begin
        rx_sum ^= b;
        if (b > MAX_DATA) begin
          r = close_frame(mfr_pkg::ST_BAD_TYPE);
          return 1;
        end
        cur_len = b[mfr_pkg::FLEN_W-1:0];
        t = store_slot();
        if (t >= 0) begin
          if (master_mode) begin
            buf_hdr[t].hw_src = own_addr;
            buf_hdr[t].dest   = cur_dest;
          end
          buf_hdr[t].src = cur_src;
          buf_hdr[t].len = b[mfr_pkg::FLEN_W-1:0];
        end
        data_cnt = '0;
        rx_phase = (b == 8'd0) ? RX_SUMD : RX_DATA;
        return 0;
      end
      RX_DATA: begin
        t = store_slot();
        if (t >= 0 && data_cnt < MAX_DATA) begin
          buf_mem[t*MAX_DATA + data_cnt]     = b;
          buf_written[t*MAX_DATA + data_cnt] = 1'b1;
        end
        rx_sum ^= b;
        data_cnt++;
        if (data_cnt >= cur_len) rx_phase = RX_SUMD;
        return 0;
      end
      RX_SUMD: begin
        if (b != rx_sum) begin
          r = close_frame(mfr_pkg::ST_CHECKSUM);
          return 1;
        end
        t = store_slot();
        if (t >= 0) buf_full[t] = 1'b1;
        r = close_frame(mfr_pkg::ST_DATA_OK);
        return 1;
      end
      RX_SUMP: begin
        r = close_frame((b == rx_sum) ? mfr_pkg::ST_POLL_OK : mfr_pkg::ST_CHECKSUM);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic bit frame_step(input bus_event_t ev, output frame_result_t r);
    int n;
    r = '0;
    n = int'(ev.node);
    case (ev.cmd)
      mfr_pkg::CMD_START: begin
        poll_node = ev.node;
        rx_sum    = '0;
        data_cnt  = '0;
        rx_phase  = RX_ADDR;
        return 0;
      end
      mfr_pkg::CMD_BYTE: return byte_step(ev.rx, ev.abit, r);
      mfr_pkg::CMD_TIMEOUT: begin
        if (rx_phase == RX_IDLE) return 0;
        r = close_frame((rx_phase == RX_ADDR) ? mfr_pkg::ST_IDLE_TMO
                                              : mfr_pkg::ST_INCOMPLETE);
        return 1;
      end
      mfr_pkg::CMD_READ: begin
        r.kind   = mfr_pkg::KIND_READ;
        r.master = master_seen;
        if (n < NODES) begin
          if (ev.idx < MAX_DATA) r.data = buf_mem[n*MAX_DATA + ev.idx];
          r.src    = buf_hdr[n].src;
          r.dest   = buf_hdr[n].dest;
          r.len    = buf_hdr[n].len;
          r.hw_src = buf_hdr[n].hw_src;
          r.full   = buf_full[n];
        end
        return 1;
      end
      mfr_pkg::CMD_RELEASE: begin
        if (n < NODES) buf_full[n] = 1'b0;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic post_event(input logic [mfr_pkg::CMD_W-1:0] cmd, input logic [7:0] b,
                            input logic abit, input logic [mfr_pkg::NODE_IN_W-1:0] node,
                            input logic [mfr_pkg::IDX_W-1:0] idx);
    queued_event_t q;
    q.ev.cmd  = cmd;
    q.ev.rx   = b;
    q.ev.abit = abit;
    q.ev.node = node;
    q.ev.idx  = idx;
    q.answers = frame_step(q.ev, q.res);
    event_q.push_back(q);
    if (cmd <= mfr_pkg::CMD_RELEASE) stim_count++;
  endtask

  task automatic post_byte(input logic [7:0] b, input logic abit);
    post_event(mfr_pkg::CMD_BYTE, b, abit, 2'($urandom), 6'($urandom));
  endtask

  task automatic post_noise(input logic [mfr_pkg::CMD_W-1:0] cmd);
    post_event(cmd, 8'($urandom), coin(), 2'($urandom), 6'($urandom));
  endtask

  // checksum byte, now and then corrupted
  task automatic post_sum();
    if ($urandom_range(0, 7) == 0) post_byte(rx_sum ^ 8'($urandom_range(1, 255)), coin());
    else post_byte(rx_sum, coin());
  endtask

  // read only data positions that some frame has written
  task automatic post_read(input int node);
    int spots [$];
    for (int i = 0; i < MAX_DATA; i++)
      if (buf_written[node*MAX_DATA + i]) spots.push_back(i);
    if (spots.size() == 0) return;
    post_event(mfr_pkg::CMD_READ, 8'($urandom), coin(), 2'(node),
               6'(spots[$urandom_range(0, spots.size() - 1)]));
  endtask

  // one frame, mostly well formed, sometimes broken or cut short
  task automatic gen_frame();
    int len;
    int cut;
    post_noise(mfr_pkg::CMD_START);
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) post_byte(8'($urandom), 1'b0);
    if (!master_mode && $urandom_range(0, 4) == 0)
      post_byte(own_addr ^ 8'($urandom_range(1, 255)), 1'b1);
    if ($urandom_range(0, 24) == 0) begin
      post_noise(mfr_pkg::CMD_TIMEOUT);
      return;
    end
    if (master_mode && $urandom_range(0, 9) == 0) begin
      post_byte(own_addr ^ 8'($urandom_range(1, 255)), 1'b1);
      return;
    end
    post_byte(own_addr, 1'b1);
    post_byte(8'($urandom), coin());
    // type byte
    case ($urandom_range(0, 19))
      0: begin
        post_byte(8'($urandom_range(2, 255)), coin());
        return;
      end
      1, 2, 3, 4: begin
        post_byte({7'd0, ~data_type}, coin());
        post_sum();
        return;
      end
      default: post_byte({7'd0, data_type}, coin());
    endcase
    post_byte(8'($urandom), coin());
    if ($urandom_range(0, 14) == 0) post_byte(8'($urandom_range(NODES, 255)), coin());
    else post_byte(8'($urandom_range(0, NODES - 1)), coin());
    if (rx_phase == RX_IDLE) return;
    case ($urandom_range(0, 15))
      0:       len = $urandom_range(MAX_DATA + 1, 255);
      1:       len = MAX_DATA;
      2, 3:    len = $urandom_range(0, MAX_DATA);
      default: len = $urandom_range(0, 6);
    endcase
    post_byte(8'(len), coin());
    if (rx_phase == RX_IDLE) return;
    cut = ($urandom_range(0, 14) == 0) ? $urandom_range(0, len) : -1;
    for (int i = 0; i <= len; i++) begin
      if (i == cut) begin
        if (coin()) post_noise(mfr_pkg::CMD_TIMEOUT);
        else post_noise(mfr_pkg::CMD_START);
        return;
      end
      if (i < len) post_byte(8'($urandom), coin());
    end
    post_sum();
  endtask

  // traffic between frames
  task automatic post_filler();
    case ($urandom_range(0, 9))
      0, 1, 2: post_read($urandom_range(0, NODES - 1));
      3, 4:    post_noise(mfr_pkg::CMD_RELEASE);
      5:       post_byte(8'($urandom), coin());
      6:       post_noise(mfr_pkg::CMD_TIMEOUT);
      7:       post_noise(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)));
      default: ;
    endcase
  endtask

  // wait until every item is on its way and every result is back
  task automatic drain();
    while (event_q.size() != 0 || in_ch.valid || answer_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mfr_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_mode(input logic [7:0] addr, input logic master, input logic dtype);
    write_reg(mfr_pkg::CFG_NODE_ADDR, addr);
    write_reg(mfr_pkg::CFG_IS_MASTER, {7'd0, master});
    write_reg(mfr_pkg::CFG_DATA_TYPE, {7'd0, dtype});
    own_addr    = addr;
    master_mode = master;
    data_type   = dtype;
  endtask

  task automatic run_phase(input int n_items);
    int  goal;
    int  half;
    bit  paused;
    goal   = stim_count + n_items;
    half   = stim_count + n_items / 2;
    paused = 1'b0;
    while (stim_count < goal) begin
      gen_frame();
      repeat ($urandom_range(0, 2)) post_filler();
      // hold the sender once until the block has answered everything
      if (!paused && stim_count >= half) begin
        drain();
        paused = 1'b1;
      end
    end
    if (rx_phase != RX_IDLE) post_noise(mfr_pkg::CMD_TIMEOUT);
    drain();
  endtask

  // ---------------------------------------------------------------- driver

  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid && on_bus.answers) answer_q.push_back(on_bus.res);
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (event_q.size() != 0) begin
        on_bus = event_q.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.command     <= on_bus.ev.cmd;
        in_ch.rx_byte     <= on_bus.ev.rx;
        in_ch.address_bit <= on_bus.ev.abit;
        in_ch.node_index  <= on_bus.ev.node;
        in_ch.byte_index  <= on_bus.ev.idx;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  int            stall_age;
  int            stall_mode;
  logic [15:0]   stall_pat;
  frame_result_t got;
  frame_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_age  = 0;
      stall_mode = 0;
      stall_pat  = '1;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind   = out_ch.result_kind;
        got.status = out_ch.status;
        got.data   = out_ch.data_byte;
        got.src    = out_ch.frame_source;
        got.dest   = out_ch.frame_dest;
        got.len    = out_ch.frame_length;
        got.hw_src = out_ch.frame_hw_source;
        got.full   = out_ch.buffer_full;
        got.master = out_ch.master_address;
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind=%0d status=%0d data=%02h", got.kind,
                     got.status, got.data);
        end else begin
          want = answer_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: exp kind=%0d st=%0d data=%02h src=%02h dst=%02h len=%0d hw=%02h full=%0d mst=%02h",
                       want.kind, want.status, want.data, want.src, want.dest, want.len,
                       want.hw_src, want.full, want.master);
              $display("                 got kind=%0d st=%0d data=%02h src=%02h dst=%02h len=%0d hw=%02h full=%0d mst=%02h",
                       got.kind, got.status, got.data, got.src, got.dest, got.len,
                       got.hw_src, got.full, got.master);
            end
          end
        end
      end
      // back-pressure pattern, reshuffled whenever stall_age reaches its limit
      stall_age++;
      if (stall_age >= 80) begin
        stall_age  = 0;
        stall_mode = $urandom_range(0, 3);
        stall_pat  = 16'($urandom);
      end
      out_ch.ready <= (stall_mode == 0) ? 1'b1 : stall_pat[stall_age % 16];
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    while (quiet < IDLE_LIMIT) @(posedge clk);
    $display("multidrop_frame_receiver verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n             = 1'b0;
    quiet             = 0;
    stim_count        = 0;
    mismatches        = 0;
    in_ch.valid       = 1'b0;
    in_ch.command     = mfr_pkg::CMD_START;
    in_ch.rx_byte     = '0;
    in_ch.address_bit = 1'b0;
    in_ch.node_index  = '0;
    in_ch.byte_index  = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = mfr_pkg::CFG_NODE_ADDR;
    cfg_ch.data       = '0;

    // predictor state after reset
    own_addr    = 8'd1;
    master_mode = 1'b0;
    data_type   = 1'b1;
    rx_phase    = RX_IDLE;
    rx_sum      = '0;
    poll_node   = '0;
    cur_hw      = '0;
    cur_src     = '0;
    cur_dest    = '0;
    cur_len     = '0;
    data_cnt    = '0;
    master_seen = '0;
    for (int i = 0; i < NODES; i++) begin
      buf_full[i] = 1'b0;
      buf_hdr[i]  = '0;
    end
    for (int i = 0; i < NODES*MAX_DATA; i++) begin
      buf_mem[i]     = '0;
      buf_written[i] = 1'b0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle byte, idle timeout, spare command
    post_byte(8'hA5, 1'b1);
    post_event(mfr_pkg::CMD_TIMEOUT, 8'h00, 1'b0, 2'd0, 6'd0);
    post_event(CMD_SPARE_HI, 8'hFF, 1'b1, 2'd3, 6'd63);
    // timeout while waiting for the address
    post_event(mfr_pkg::CMD_START, 8'h00, 1'b0, 2'd3, 6'd0);
    post_event(mfr_pkg::CMD_TIMEOUT, 8'hFF, 1'b1, 2'd3, 6'd63);
    // slave data frame after noise and a foreign address
    post_event(mfr_pkg::CMD_START, 8'hFF, 1'b1, 2'd0, 6'd63);
    post_byte(8'h00, 1'b0);
    post_byte(8'h02, 1'b1);
    post_byte(8'h01, 1'b1);
    post_byte(8'hFF, 1'b0);
    post_byte(8'h01, 1'b1);
    post_byte(8'h80, 1'b0);
    post_byte(8'h03, 1'b0);
    post_byte(8'h02, 1'b1);
    post_byte(8'h00, 1'b0);
    post_byte(8'hFF, 1'b1);
    post_byte(rx_sum, 1'b0);
    post_event(mfr_pkg::CMD_READ, 8'h00, 1'b0, 2'd1, 6'd0);
    post_event(mfr_pkg::CMD_READ, 8'hFF, 1'b1, 2'd1, 6'd1);
    post_event(mfr_pkg::CMD_RELEASE, 8'h00, 1'b0, 2'd1, 6'd0);
    // poll frame with a bad checksum
    post_event(mfr_pkg::CMD_START, 8'h00, 1'b0, 2'd2, 6'd0);
    post_byte(8'h01, 1'b1);
    post_byte(8'h42, 1'b0);
    post_byte(8'h00, 1'b0);
    post_byte(rx_sum ^ 8'h01, 1'b0);
    // frame cut short by a timeout
    post_event(mfr_pkg::CMD_START, 8'h00, 1'b0, 2'd1, 6'd0);
    post_byte(8'h01, 1'b1);
    post_byte(8'h7E, 1'b1);
    post_event(mfr_pkg::CMD_TIMEOUT, 8'h00, 1'b0, 2'd0, 6'd0);
    drain();

    // random phases over bus modes and addresses
    set_mode(8'd2, 1'b1, 1'b1);
    run_phase(PHASE_ITEMS);
    set_mode(8'd3, 1'b0, 1'b0);
    run_phase(PHASE_ITEMS);
    set_mode(8'd0, 1'b1, 1'b0);
    run_phase(PHASE_ITEMS);
    set_mode(8'd255, 1'b0, 1'b1);
    run_phase(PHASE_ITEMS);
    set_mode(8'd255, 1'b1, 1'b0);
    run_phase(PHASE_ITEMS);
    set_mode(8'd1, 1'b0, 1'b1);
    run_phase(PHASE_ITEMS);
    set_mode(coin() ? 8'($urandom_range(0, NODES - 1)) : 8'($urandom), coin(), coin());
    run_phase(PHASE_ITEMS);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("multidrop_frame_receiver verification clean");
    end else begin
      $display("multidrop_frame_receiver verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mfr_pkg.sv
hw/rtl/mfr_if.sv
hw/rtl/mfr_ram.sv
hw/rtl/mfr_parse.sv
hw/rtl/multidrop_frame_receiver.sv
sim/tb_multidrop_frame_receiver.sv
